### sv/mm_pkg.sv
`timescale 1ns / 1ps

package mm_pkg;

  // Row and column indexes on the result ports, and the inner index in the chain.
  localparam int IDX_W = 3;
  // Width of a product element, signed Q19.16.
  localparam int SUM_W = 36;

  // Control that travels down the chain of cells beside the A element.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             lastk;
    logic [IDX_W-1:0] k;
  } ctl_t;

endpackage

### sv/mm_ram.sv
`timescale 1ns / 1ps

module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/mm_cell.sv
`timescale 1ns / 1ps

module mm_cell #(
  parameter int DATA_WIDTH = 16,
  parameter int MAX_DIM    = 8,
  parameter int COL        = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          b_we,
  input  logic [mm_pkg::IDX_W-1:0]      b_row,
  input  logic [mm_pkg::IDX_W-1:0]      b_col,
  input  logic [DATA_WIDTH-1:0]         b_data,
  input  logic signed [DATA_WIDTH-1:0]  a_in,
  input  mm_pkg::ctl_t                  ctl_in,
  output logic signed [DATA_WIDTH-1:0]  a_out,
  output mm_pkg::ctl_t                  ctl_out,
  output logic                          done,
  output logic [mm_pkg::SUM_W-1:0]      acc
);

  import mm_pkg::*;

  localparam int KW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  // This cell keeps column COL of B, one entry per inner index.
  logic [DATA_WIDTH-1:0]          bcol [MAX_DIM];
  logic signed [DATA_WIDTH-1:0]   b_sel;
  logic signed [2*DATA_WIDTH-1:0] prod;
  logic                           p_valid;
  logic                           p_first;
  logic                           p_last;

  assign b_sel = $signed(bcol[ctl_in.k[KW-1:0]]);

  always_ff @(posedge clk) begin
    if (b_we && b_col == IDX_W'(COL)) begin
      bcol[b_row[KW-1:0]] <= b_data;
    end
  end

  always_ff @(posedge clk) begin
    a_out   <= a_in;
    prod    <= a_in * b_sel;
    p_first <= ctl_in.first;
    p_last  <= ctl_in.lastk;
    if (p_valid) begin
      acc <= p_first ? SUM_W'(prod) : acc + SUM_W'(prod);
    end
    if (rst) begin
      ctl_out <= '0;
      p_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      ctl_out <= ctl_in;
      p_valid <= ctl_in.valid;
      done    <= p_valid & p_last;
    end
  end

endmodule

### sv/matrix_multiply.sv
`timescale 1ns / 1ps
// Results: the product comes out row by row, each row in column order, after
// the edge that takes the last B item.
// Loading accepts items only while busy is low; the product then runs through
// the chain of MAC cells and its drain, and no new item is taken until it ends.
// Reset clears the control, sets every dimension register to 8 and empties the run.
// The receiver cannot stall: each result is shown for exactly one cycle.

module matrix_multiply #(
  parameter int MAX_DIM    = 8,
  parameter int DATA_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [DATA_WIDTH-1:0]  value,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic                          valid,
  output logic signed [mm_pkg::SUM_W-1:0] sum,
  output logic [mm_pkg::IDX_W-1:0]      out_row,
  output logic [mm_pkg::IDX_W-1:0]      out_col,
  output logic                          last,
  output logic                          error
);

  import mm_pkg::*;

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DRAIN   = MAX_DIM + 6;
  localparam int DCW     = $clog2(DRAIN + 1);
  localparam logic [3:0] DIM_RESET = 4'd8;
  localparam logic [3:0] DIM_MAX   = 4'(MAX_DIM);

  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  typedef enum logic [2:0] {
    S_LOAD  = 3'b001,
    S_ISSUE = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  // A register of zero counts as one, and one above MAX_DIM as MAX_DIM.
  function automatic logic [3:0] eff_dim(input logic [3:0] r);
    logic [3:0] d;
    d = r;
    if (r == 4'd0) begin
      d = 4'd1;
    end else if (r > DIM_MAX) begin
      d = DIM_MAX;
    end
    return d;
  endfunction

  state_t state;

  logic [3:0] a_rows, a_cols, b_rows, b_cols;
  logic [3:0] ar, ac, br, bc;
  logic [7:0] na, nb, total;
  logic [7:0] load_count;
  logic       accept, cfg_we, in_a, last_item, match, err_fire;

  logic [IDX_W-1:0] bk, bj;
  logic [IDX_W-1:0] kc, row;
  logic [AW-1:0]    base;
  logic [DCW-1:0]   drain;

  logic [DATA_WIDTH-1:0]        rdata;
  ctl_t                         ctl0;
  logic signed [DATA_WIDTH-1:0] a_link [MAX_DIM];
  ctl_t                         ctl_link [MAX_DIM];
  logic [MAX_DIM-1:0]           done;
  logic [SUM_W-1:0]             acc [MAX_DIM];

  logic             hit;
  logic [SUM_W-1:0] hit_sum;
  logic [IDX_W-1:0] hit_col;

  assign ar    = eff_dim(a_rows);
  assign ac    = eff_dim(a_cols);
  assign br    = eff_dim(b_rows);
  assign bc    = eff_dim(b_cols);
  assign na    = {4'b0, ar} * {4'b0, ac};
  assign nb    = {4'b0, br} * {4'b0, bc};
  assign total = na + nb;

  assign busy      = (state != S_LOAD);
  assign accept    = start & ~busy;
  assign in_a      = (load_count < na);
  assign last_item = ((load_count + 8'd1) == total);
  assign match     = (ac == br);
  assign err_fire  = accept & last_item & ~match;

  // Configuration port: always ready, registers at byte addresses 0, 4, 8 and 12.
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_A_ROWS: prdata = {28'b0, a_rows};
      REG_A_COLS: prdata = {28'b0, a_cols};
      REG_B_ROWS: prdata = {28'b0, b_rows};
      REG_B_COLS: prdata = {28'b0, b_cols};
      default:    prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= DIM_RESET;
      a_cols <= DIM_RESET;
      b_rows <= DIM_RESET;
      b_cols <= DIM_RESET;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_A_ROWS: a_rows <= pwdata[3:0];
        REG_A_COLS: a_cols <= pwdata[3:0];
        REG_B_ROWS: b_rows <= pwdata[3:0];
        REG_B_COLS: b_cols <= pwdata[3:0];
        default:    a_rows <= a_rows;
      endcase
    end
  end

  // A is kept in a RAM and read back one element a cycle while a row is issued.
  mm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store_a (
    .clk   (clk),
    .we    (accept & in_a),
    .waddr (load_count[AW-1:0]),
    .wdata (value),
    .raddr (base + AW'(kc)),
    .rdata (rdata)
  );

  // Sequencer. While loading, bk and bj follow the row and column of the next
  // B element, so each cell picks up its own column of B as it goes by.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      bk         <= '0;
      bj         <= '0;
      kc         <= '0;
      row        <= '0;
      base       <= '0;
      drain      <= '0;
      ctl0       <= '0;
    end else begin
      ctl0.valid <= (state == S_ISSUE);
      ctl0.k     <= kc;
      ctl0.first <= (kc == '0);
      ctl0.lastk <= ({1'b0, kc} == ac - 4'd1);
      case (state)
        S_LOAD: begin
          if (cfg_we) begin
            load_count <= '0;
            bk         <= '0;
            bj         <= '0;
          end else if (accept) begin
            if (in_a) begin
              bk <= '0;
              bj <= '0;
            end else if ({1'b0, bj} == bc - 4'd1) begin
              bj <= '0;
              bk <= bk + 1'b1;
            end else begin
              bj <= bj + 1'b1;
            end
            if (last_item) begin
              load_count <= '0;
              if (match) begin
                state <= S_ISSUE;
                row   <= '0;
                kc    <= '0;
                base  <= '0;
              end
            end else begin
              load_count <= load_count + 8'd1;
            end
          end
        end
        S_ISSUE: begin
          if ({1'b0, kc} == ac - 4'd1) begin
            kc    <= '0;
            drain <= DCW'(DRAIN);
            state <= S_DRAIN;
          end else begin
            kc <= kc + 1'b1;
          end
        end
        S_DRAIN: begin
          drain <= drain - 1'b1;
          // The whole row has left the chain before the row index moves on.
          if (drain == DCW'(1)) begin
            if ({1'b0, row} == ar - 4'd1) begin
              state <= S_LOAD;
            end else begin
              row   <= row + 1'b1;
              base  <= base + AW'(ac);
              state <= S_ISSUE;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // The chain: each A element of the current row enters cell 0 and moves one
  // cell a cycle, so cell j finishes its dot product in the cycle after cell j-1
  // and the row comes out in column order.
  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] a_in;
    ctl_t                         c_in;
    if (j == 0) begin : g_head
      assign a_in = $signed(rdata);
      assign c_in = ctl0;
    end else begin : g_body
      assign a_in = a_link[j-1];
      assign c_in = ctl_link[j-1];
    end
    mm_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .MAX_DIM    (MAX_DIM),
      .COL        (j)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .b_we    (accept & ~in_a),
      .b_row   (bk),
      .b_col   (bj),
      .b_data  (value),
      .a_in    (a_in),
      .ctl_in  (c_in),
      .a_out   (a_link[j]),
      .ctl_out (ctl_link[j]),
      .done    (done[j]),
      .acc     (acc[j])
    );
  end

  // At most one cell finishes in any cycle; cells beyond b_cols are ignored.
  always_comb begin
    hit     = 1'b0;
    hit_sum = '0;
    hit_col = '0;
    for (int j = 0; j < MAX_DIM; j++) begin
      if (done[j] && (4'(j) < bc)) begin
        hit     = 1'b1;
        hit_sum = hit_sum | acc[j];
        hit_col = IDX_W'(j);
      end
    end
  end

  // Result register. A dimension mismatch gives a single error item instead.
  always_ff @(posedge clk) begin
    if (err_fire) begin
      sum     <= '0;
      out_row <= '0;
      out_col <= '0;
      last    <= 1'b1;
      error   <= 1'b1;
    end else begin
      sum     <= hit_sum;
      out_row <= row;
      out_col <= hit_col;
      last    <= ({1'b0, row} == ar - 4'd1) && ({1'b0, hit_col} == bc - 4'd1);
      error   <= 1'b0;
    end
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= hit | err_fire;
    end
  end

endmodule
